/* src/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, codes and cell control type for the sorted array table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

/* src/sat_cell.sv */
// ----------------------------------------------------------------------------
// sat_cell
// One slot of the sorted row: compares its entry with the broadcast key and
// takes the key or a neighbor's entry on insert and remove.
// ----------------------------------------------------------------------------
module sat_cell
  import sat_pkg::*;
#(
  parameter int POS       = 0,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  cmd_t                 cmd_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] left_entry_i,
  input  logic                 left_lt_i,
  input  logic [KEY_WIDTH-1:0] right_entry_i,
  output logic [KEY_WIDTH-1:0] entry_o,
  output logic                 lt_o
);

  logic [KEY_WIDTH-1:0] entry_q;
  logic                 valid;
  logic                 rem_shift;

  assign valid     = int'(cmd_i.count) > POS;
  assign rem_shift = POS >= int'(cmd_i.idx);
  assign lt_o      = valid && (entry_q < key_i);
  assign entry_o   = entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en && !lt_o) begin
      // first slot not below the key takes it, later slots shift up
      entry_q <= left_lt_i ? key_i : left_entry_i;
    end else if (cmd_i.rem_en && rem_shift) begin
      entry_q <= right_entry_i;
    end
  end

endmodule

/* src/sorted_array_table.sv */
// Result strobe done_o rises in the cycle after start is taken.
// Throughput: one operation per cycle; all cells compare and shift in the
// same cycle, so busy stays low.
// Reset: entry count cleared, capacity set to 16; cell contents undefined
// until written. The result receiver cannot stall.
// ----------------------------------------------------------------------------
// sorted_array_table
// Ascending table of unsigned keys held in a row of cells, with insert,
// lookup by index and remove by index.
// ----------------------------------------------------------------------------
module sorted_array_table
  import sat_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic [IDX_W-1:0]  index_i,
  output logic              done_o,
  output logic [DATA_W-1:0] value_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [ST_W-1:0]   status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i
);

  localparam int RD_N = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);

  logic [CNT_W-1:0]     capacity_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 done_q;
  logic [DATA_W-1:0]    value_q, value_d;
  logic [ST_W-1:0]      status_q, status_d;
  logic                 accept;
  logic                 full;
  logic                 in_range;
  logic [KEY_WIDTH-1:0] key_w;
  logic [KEY_WIDTH-1:0] rd_entry;
  cmd_t                 cmd;
  logic [KEY_WIDTH-1:0] entry_w [DEPTH];
  logic                 lt_w    [DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign key_w       = KEY_WIDTH'(key_i);

  assign full     = (count_q >= capacity_q) || (int'(count_q) >= DEPTH);
  assign in_range = CNT_W'(index_i) < count_q;

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (index_i == IDX_W'(i)) begin
        rd_entry = entry_w[i];
      end
    end
  end

  always_comb begin
    cmd.ins_en = 1'b0;
    cmd.rem_en = 1'b0;
    cmd.idx    = index_i;
    cmd.count  = count_q;
    count_d    = count_q;
    value_d    = '0;
    status_d   = ST_OK;
    unique case (func_i)
      FUNC_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins_en = accept;
          count_d    = count_q + CNT_W'(1);
        end
      end
      FUNC_LOOKUP: begin
        if (in_range) begin
          value_d = DATA_W'(rd_entry);
        end else begin
          status_d = ST_RANGE;
        end
      end
      FUNC_REMOVE: begin
        if (in_range) begin
          cmd.rem_en = accept;
          count_d    = count_q - CNT_W'(1);
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_entry;
    logic                 left_lt;
    logic [KEY_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = key_w;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_lt    = lt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    sat_cell #(
      .POS       (i),
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .key_i         (key_w),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .lt_o          (lt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  // count_q already holds the post-op count while the beat is shown
  assign done_o   = done_q;
  assign value_o  = value_q;
  assign count_o  = count_q;
  assign status_o = status_q;

endmodule

/* src/sat_checker.sv */
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on result timing and status consistency.
// ----------------------------------------------------------------------------
module sat_checker
  import sat_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [DATA_W-1:0] value_o,
  input logic [CNT_W-1:0]  count_o,
  input logic [ST_W-1:0]   status_o
);

  a_one_beat_per_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> done_o == $past(start && !busy))
    else $error("result beat does not match accepted operation");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && done_o && status_o != ST_OK |-> $stable(count_o))
    else $error("failed operation changed the count");

  a_range_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_RANGE |-> value_o == '0)
    else $error("out of range result carries a value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> count_o <= CNT_W'(DEPTH_DEF))
    else $error("count exceeds table depth");

endmodule

bind sorted_array_table sat_checker u_sat_checker (.*);
